@@ hdl/assert_macros.svh @@
// assertion macros shared by the particle height engine modules
// no dependencies; included by every file that checks its own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CPHE_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define CPHE_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define CPHE_ASSERT(label, clk, rst, prop)
`define CPHE_NEVER(label, clk, rst, cond)
`endif
`endif

@@ hdl/cphe_pkg.sv @@
// shared constants, command codes, move tables and control types
// no dependencies; imported by every module of the particle height engine but cphe_ram
`timescale 1ns / 1ps

package cphe_pkg;

   localparam int PARTICLE_COUNT = 4096;
   localparam int IDX_W          = $clog2(PARTICLE_COUNT);
   localparam int INDEX_FIELD_W  = 12;
   localparam int HEIGHT_W       = 32;
   localparam int CMD_W          = 2;
   localparam int STEPS_W        = 4;
   localparam int CSR_ADDR_W     = 3;
   localparam int CSR_DATA_W     = 32;
   // memory word: movable flag, previous height, current height
   localparam int WORD_W         = 2 * HEIGHT_W + 1;
   localparam int COEF_W         = 17;
   localparam int TABLE_LENGTH   = 15;

   localparam logic [CMD_W-1:0] CMD_LOAD      = 2'd0;
   localparam logic [CMD_W-1:0] CMD_INTEGRATE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CONSTRAIN = 2'd2;
   localparam logic [CMD_W-1:0] CMD_READ      = 2'd3;

   localparam logic [COEF_W-1:0] DAMP_KEEP     = 17'd64881;
   localparam logic [COEF_W-1:0] HALF_BEYOND   = 17'd32768;
   localparam logic [COEF_W-1:0] SINGLE_BEYOND = 17'd65536;

   typedef struct packed {
      logic capture;
      logic mul_en;
      logic upd_a;
      logic upd_b;
      logic rsp_load;
   } ctl_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             rsp_free;
   } sts_type;

   // share of the difference moved when only one particle is free
   function automatic logic [COEF_W-1:0] single_move(input logic [STEPS_W-1:0] steps);
      logic [COEF_W-1:0] c;
      case (steps)
         4'd0:    c = 17'd0;
         4'd1:    c = 17'd19661;
         4'd2:    c = 17'd33423;
         4'd3:    c = 17'd43057;
         4'd4:    c = 17'd49801;
         4'd5:    c = 17'd54521;
         4'd6:    c = 17'd57826;
         4'd7:    c = 17'd60139;
         4'd8:    c = 17'd61758;
         4'd9:    c = 17'd62892;
         4'd10:   c = 17'd63685;
         4'd11:   c = 17'd64240;
         4'd12:   c = 17'd64629;
         4'd13:   c = 17'd64901;
         4'd14:   c = 17'd65092;
         default: c = SINGLE_BEYOND;
      endcase
      return c;
   endfunction

   // share moved by each particle when both are free
   function automatic logic [COEF_W-1:0] half_move(input logic [STEPS_W-1:0] steps);
      logic [COEF_W-1:0] c;
      case (steps)
         4'd0:    c = 17'd0;
         4'd1:    c = 17'd19661;
         4'd2:    c = 17'd27525;
         4'd3:    c = 17'd30671;
         4'd4:    c = 17'd31929;
         4'd5:    c = 17'd32434;
         4'd6:    c = 17'd32637;
         4'd7:    c = 17'd32716;
         4'd8:    c = 17'd32748;
         4'd9:    c = 17'd32761;
         4'd10:   c = 17'd32761;
         default: c = HALF_BEYOND;
      endcase
      return c;
   endfunction

   // clamp a 36-bit signed sum to the 32-bit signed range
   function automatic logic [HEIGHT_W-1:0] sat32(input logic signed [35:0] v);
      logic [HEIGHT_W-1:0] r;
      if (!v[35] && (|v[34:31])) begin
         r = 32'h7FFF_FFFF;
      end else if (v[35] && !(&v[34:31])) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

@@ hdl/cphe_ram.sv @@
// generic single-write, dual-read memory with registered read data
// no dependencies
`timescale 1ns / 1ps

module cphe_ram #(
   parameter int DATA_W = 32,
   parameter int DEPTH  = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [DATA_W-1:0]        rd_data_a,
   output logic [DATA_W-1:0]        rd_data_b
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_a_ff;
   logic [DATA_W-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem[rd_addr_a];
      rd_data_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

@@ hdl/cphe_ctrl.sv @@
// command sequencer: fetch, multiply, write back one or two entries, respond
// depends on cphe_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cphe_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cphe_pkg::sts_type sts,
   output cphe_pkg::ctl_type ctl
);

   import cphe_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_FETCH = 3'd1;
   localparam logic [2:0] S_MUL   = 3'd2;
   localparam logic [2:0] S_UPDA  = 3'd3;
   localparam logic [2:0] S_UPDB  = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      unique case (state_ff)
         S_IDLE: begin
            ctl.capture = req_valid;
            if (req_valid) begin
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            state_in = S_MUL;
         end
         S_MUL: begin
            ctl.mul_en = 1'b1;
            state_in   = S_UPDA;
         end
         S_UPDA: begin
            ctl.upd_a = 1'b1;
            state_in  = (sts.cmd == CMD_CONSTRAIN) ? S_UPDB : S_DONE;
         end
         S_UPDB: begin
            ctl.upd_b = 1'b1;
            state_in  = S_DONE;
         end
         S_DONE: begin
            ctl.rsp_load = sts.rsp_free;
            if (sts.rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   `CPHE_ASSERT(a_accept_starts_fetch, clock, reset, (state_ff == S_IDLE && req_valid) |=> (state_ff == S_FETCH))
   `CPHE_ASSERT(a_second_write_only_pair, clock, reset, (state_ff == S_UPDB) |-> (sts.cmd == CMD_CONSTRAIN))
   `CPHE_ASSERT(a_done_holds_when_busy, clock, reset, (state_ff == S_DONE && !sts.rsp_free) |=> (state_ff == S_DONE))

endmodule

@@ hdl/cphe_datapath.sv @@
// particle update datapath: command latch, rounded multiply, saturating
// updates, memory write words and the result register; depends on cphe_pkg
`timescale 1ns / 1ps

module cphe_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  cphe_pkg::ctl_type              ctl,
   output cphe_pkg::sts_type              sts,
   input  logic [cphe_pkg::CMD_W-1:0]     req_command,
   input  logic [cphe_pkg::INDEX_FIELD_W-1:0] req_first_index,
   input  logic [cphe_pkg::INDEX_FIELD_W-1:0] req_partner_index,
   input  logic signed [cphe_pkg::HEIGHT_W-1:0] req_load_height,
   input  logic                           req_load_movable,
   input  logic [cphe_pkg::STEPS_W-1:0]   rigidness_steps,
   input  logic signed [cphe_pkg::HEIGHT_W-1:0] fall_step,
   output logic                           ram_wr_en,
   output logic [cphe_pkg::IDX_W-1:0]     ram_wr_addr,
   output logic [cphe_pkg::WORD_W-1:0]    ram_wr_data,
   output logic [cphe_pkg::IDX_W-1:0]     ram_rd_addr_a,
   output logic [cphe_pkg::IDX_W-1:0]     ram_rd_addr_b,
   input  logic [cphe_pkg::WORD_W-1:0]    ram_rd_data_a,
   input  logic [cphe_pkg::WORD_W-1:0]    ram_rd_data_b,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [cphe_pkg::HEIGHT_W-1:0] rsp_first_height,
   output logic signed [cphe_pkg::HEIGHT_W-1:0] rsp_partner_height,
   output logic                           rsp_first_movable
);

   import cphe_pkg::*;

   localparam int PROD_W = HEIGHT_W + COEF_W;
   localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(32768);

   // latched command
   logic [CMD_W-1:0]    cmd_ff;
   logic [IDX_W-1:0]    a_idx_ff;
   logic [IDX_W-1:0]    b_idx_ff;
   logic [HEIGHT_W-1:0] ld_h_ff;
   logic                ld_m_ff;

   // multiply stage
   logic [HEIGHT_W-1:0] ha_in, preva_in, hb_in, prevb_in;
   logic                ma_in, mb_in;
   logic [HEIGHT_W-1:0] ha_ff, preva_ff, hb_ff, prevb_ff;
   logic                ma_ff, mb_ff;
   logic signed [HEIGHT_W:0] x_in;
   logic [HEIGHT_W:0]   mag_full;
   logic [COEF_W-1:0]   coef_in;
   logic [PROD_W-1:0]   prod_in, prod_ff;
   logic                neg_in, neg_ff;

   // update stage
   logic [PROD_W-1:0]   rnd;
   logic [HEIGHT_W:0]   rmag;
   logic signed [35:0]  corr, ha36, hb36, fall36;
   logic [HEIGHT_W-1:0] new_a_in, new_prev_a_in, new_b_in;
   logic                new_m_in;
   logic [HEIGHT_W-1:0] new_a_ff, new_b_ff;
   logic                new_m_ff;

   // result register
   logic                rsp_valid_in, rsp_valid_ff;
   logic [HEIGHT_W-1:0] rsp_first_ff, rsp_partner_ff, rsp_partner_in;
   logic                rsp_mov_ff;

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         cmd_ff   <= req_command;
         a_idx_ff <= req_first_index[IDX_W-1:0];
         b_idx_ff <= req_partner_index[IDX_W-1:0];
         ld_h_ff  <= req_load_height;
         ld_m_ff  <= req_load_movable;
      end
   end

   assign ram_rd_addr_a = a_idx_ff;
   assign ram_rd_addr_b = b_idx_ff;

   // unpack both entries, form the signed delta and its magnitude
   always_comb begin
      ha_in    = ram_rd_data_a[HEIGHT_W-1:0];
      preva_in = ram_rd_data_a[2*HEIGHT_W-1:HEIGHT_W];
      ma_in    = ram_rd_data_a[WORD_W-1];
      hb_in    = ram_rd_data_b[HEIGHT_W-1:0];
      prevb_in = ram_rd_data_b[2*HEIGHT_W-1:HEIGHT_W];
      mb_in    = ram_rd_data_b[WORD_W-1];
      if (cmd_ff == CMD_INTEGRATE) begin
         x_in    = $signed({ha_in[HEIGHT_W-1], ha_in}) - $signed({preva_in[HEIGHT_W-1], preva_in});
         coef_in = DAMP_KEEP;
      end else begin
         x_in    = $signed({hb_in[HEIGHT_W-1], hb_in}) - $signed({ha_in[HEIGHT_W-1], ha_in});
         coef_in = (ma_in && mb_in) ? half_move(rigidness_steps)
                                    : single_move(rigidness_steps);
      end
      neg_in   = x_in[HEIGHT_W];
      mag_full = neg_in ? (~x_in + 1'b1) : x_in;
      // magnitude of a difference of two 32-bit values stays below 2^32
      prod_in  = {{COEF_W{1'b0}}, mag_full[HEIGHT_W-1:0]} * {{HEIGHT_W{1'b0}}, coef_in};
   end

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         ha_ff    <= ha_in;
         preva_ff <= preva_in;
         ma_ff    <= ma_in;
         hb_ff    <= hb_in;
         prevb_ff <= prevb_in;
         mb_ff    <= mb_in;
         prod_ff  <= prod_in;
         neg_ff   <= neg_in;
      end
   end

   // round half away from zero, then apply the correction
   always_comb begin
      rnd    = prod_ff + ROUND_HALF;
      rmag   = rnd[PROD_W-1:16];
      corr   = neg_ff ? (36'sd0 - $signed({3'b000, rmag})) : $signed({3'b000, rmag});
      ha36   = {{4{ha_ff[HEIGHT_W-1]}}, ha_ff};
      hb36   = {{4{hb_ff[HEIGHT_W-1]}}, hb_ff};
      fall36 = {{4{fall_step[HEIGHT_W-1]}}, fall_step};
      new_a_in      = ha_ff;
      new_prev_a_in = preva_ff;
      new_m_in      = ma_ff;
      new_b_in      = hb_ff;
      unique case (cmd_ff)
         CMD_LOAD: begin
            new_a_in      = ld_h_ff;
            new_prev_a_in = ld_h_ff;
            new_m_in      = ld_m_ff;
         end
         CMD_INTEGRATE: begin
            if (ma_ff) begin
               new_a_in      = sat32(ha36 + corr + fall36);
               new_prev_a_in = ha_ff;
            end
         end
         CMD_CONSTRAIN: begin
            if (ma_ff) begin
               new_a_in = sat32(ha36 + corr);
            end
            if (mb_ff) begin
               new_b_in = sat32(hb36 - corr);
            end
         end
         CMD_READ: begin
            new_a_in = ha_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.upd_a) begin
         new_a_ff <= new_a_in;
         new_b_ff <= new_b_in;
         new_m_ff <= new_m_in;
      end
   end

   // first entry written in the S_UPDA state, partner in S_UPDB (constrain only)
   always_comb begin
      ram_wr_en   = ctl.upd_a || ctl.upd_b;
      ram_wr_addr = ctl.upd_b ? b_idx_ff : a_idx_ff;
      ram_wr_data = ctl.upd_b ? {mb_ff, prevb_ff, new_b_ff}
                              : {new_m_in, new_prev_a_in, new_a_in};
   end

   assign rsp_partner_in = (cmd_ff == CMD_CONSTRAIN) ? new_b_ff : '0;
   assign sts.cmd        = cmd_ff;
   assign sts.rsp_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rsp_load) begin
         rsp_first_ff   <= new_a_ff;
         rsp_partner_ff <= rsp_partner_in;
         rsp_mov_ff     <= new_m_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_first_height   = rsp_first_ff;
   assign rsp_partner_height = rsp_partner_ff;
   assign rsp_first_movable  = rsp_mov_ff;

endmodule

@@ hdl/cloth_particle_height_engine.sv @@
// cloth particle height engine top: register port, particle memory, sequencer, datapath
// sequence: fetch, multiply, update, then the result is registered on leaving done; a constrain adds a partner update
// one command at a time, a new transfer is taken only when idle; a waiting result delays the next
//   transfer in
// reset: synchronous, clears sequencer and result valid; rigidness_steps 3, fall_step 0
// depends on cphe_pkg, cphe_ram, cphe_ctrl, cphe_datapath and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cloth_particle_height_engine (
   input  logic                                   clock,
   input  logic                                   reset,
   // input channel
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [cphe_pkg::CMD_W-1:0]             req_command,
   input  logic [cphe_pkg::INDEX_FIELD_W-1:0]     req_first_index,
   input  logic [cphe_pkg::INDEX_FIELD_W-1:0]     req_partner_index,
   input  logic signed [cphe_pkg::HEIGHT_W-1:0]   req_load_height,
   input  logic                                   req_load_movable,
   // result channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [cphe_pkg::HEIGHT_W-1:0]   rsp_first_height,
   output logic signed [cphe_pkg::HEIGHT_W-1:0]   rsp_partner_height,
   output logic                                   rsp_first_movable,
   // register port
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [cphe_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [cphe_pkg::CSR_DATA_W-1:0]        csr_pwdata,
   output logic [cphe_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                   csr_pready
);

   import cphe_pkg::*;

   // register select is address bit 2: rigidness_steps at 0, fall_step at 4
   localparam logic REG_RIGIDNESS = 1'b0;
   localparam logic REG_FALL      = 1'b1;

   logic                csr_write;
   logic [STEPS_W-1:0]  rigidness_steps_ff, rigidness_steps_in;
   logic [HEIGHT_W-1:0] fall_step_ff, fall_step_in;

   ctl_type             ctl;
   sts_type             sts;

   logic                ram_wr_en;
   logic [IDX_W-1:0]    ram_wr_addr, ram_rd_addr_a, ram_rd_addr_b;
   logic [WORD_W-1:0]   ram_wr_data, ram_rd_data_a, ram_rd_data_b;

   // ---------------------------------------------------------------
   // register port: zero-wait, written on the access phase
   // ---------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      rigidness_steps_in = rigidness_steps_ff;
      fall_step_in       = fall_step_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            REG_RIGIDNESS: rigidness_steps_in = csr_pwdata[STEPS_W-1:0];
            REG_FALL:      fall_step_in       = csr_pwdata[HEIGHT_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rigidness_steps_ff <= STEPS_W'(3);
         fall_step_ff       <= '0;
      end else begin
         rigidness_steps_ff <= rigidness_steps_in;
         fall_step_ff       <= fall_step_in;
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_RIGIDNESS: csr_prdata = {{(CSR_DATA_W-STEPS_W){1'b0}}, rigidness_steps_ff};
         REG_FALL:      csr_prdata = fall_step_ff;
      endcase
   end

   // ---------------------------------------------------------------
   // particle memory: one word per particle holding movable flag,
   // previous height and height; not enforced, the user reads an entry only after a load
   // ---------------------------------------------------------------
   cphe_ram #(
      .DATA_W (WORD_W),
      .DEPTH  (PARTICLE_COUNT)
   ) u_ram (
      .clock     (clock),
      .wr_en     (ram_wr_en),
      .wr_addr   (ram_wr_addr),
      .wr_data   (ram_wr_data),
      .rd_addr_a (ram_rd_addr_a),
      .rd_addr_b (ram_rd_addr_b),
      .rd_data_a (ram_rd_data_a),
      .rd_data_b (ram_rd_data_b)
   );

   // sequencer: one command at a time, input transfer only when idle
   cphe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   // datapath: multiply, round, saturate, write back, result register
   cphe_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .ctl                (ctl),
      .sts                (sts),
      .req_command        (req_command),
      .req_first_index    (req_first_index),
      .req_partner_index  (req_partner_index),
      .req_load_height    (req_load_height),
      .req_load_movable   (req_load_movable),
      .rigidness_steps    (rigidness_steps_ff),
      .fall_step          (fall_step_ff),
      .ram_wr_en          (ram_wr_en),
      .ram_wr_addr        (ram_wr_addr),
      .ram_wr_data        (ram_wr_data),
      .ram_rd_addr_a      (ram_rd_addr_a),
      .ram_rd_addr_b      (ram_rd_addr_b),
      .ram_rd_data_a      (ram_rd_data_a),
      .ram_rd_data_b      (ram_rd_data_b),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_first_height   (rsp_first_height),
      .rsp_partner_height (rsp_partner_height),
      .rsp_first_movable  (rsp_first_movable)
   );

   // a rigidness write lands in the register on the next cycle
   `CPHE_ASSERT(a_rigidness_write, clock, reset, (csr_write && csr_paddr[2] == REG_RIGIDNESS) |=> (rigidness_steps_ff == $past(csr_pwdata[STEPS_W-1:0])))

endmodule
